// ===== sv/ipv4_longest_prefix_route_table_unit_defines.svh =====
// assertion macros for the ipv4 longest prefix route table unit
`ifndef IPV4_LONGEST_PREFIX_ROUTE_TABLE_UNIT_DEFINES_SVH
`define IPV4_LONGEST_PREFIX_ROUTE_TABLE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/ipv4lpm_pkg.sv =====
// types, codes and helpers shared by the route table modules
`timescale 1ns / 1ps
`default_nettype none
package ipv4lpm_pkg;

   typedef enum logic [1:0] {
      OP_UPSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_BAD_LEN = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISS    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_SCAN = 2'd1,
      FSM_HOLD = 2'd2
   } state_type;

   localparam logic [5:0] MAX_LEN = 6'd32;

   typedef struct packed {
      op_type      op;
      logic [31:0] prefix;
      logic [5:0]  prefix_len;
      logic [31:0] metric;
      logic [31:0] next_hop;
      logic [31:0] lookup_addr;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] best_prefix;
      logic [5:0]  best_len;
      logic [31:0] best_metric;
      logic [31:0] best_hop;
      logic [6:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] prefix;
      logic [5:0]  len;
      logic [31:0] metric;
      logic [31:0] hop;
   } entry_type;

   typedef struct packed {
      logic        valid;
      op_type      op;
      entry_type   key;
      logic [31:0] addr;
      logic        found;
      logic        hit;
      entry_type   best;
      entry_type   last;
   } tok_type;

   typedef struct packed {
      logic      we;
      entry_type ent;
   } wr_type;

   function automatic logic [31:0] len_mask(input logic [5:0] len);
      return ~(32'hFFFF_FFFF >> len);
   endfunction

endpackage
`default_nettype wire

// ===== sv/ipv4lpm_cell.sv =====
// one route slot of the table with its stage of the search chain
`timescale 1ns / 1ps
`default_nettype none
module ipv4lpm_cell #(
   parameter int IDX   = 0,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ipv4lpm_pkg::tok_type  up_tok,
   input  wire logic [IDX_W-1:0]      up_slot,
   output ipv4lpm_pkg::tok_type       dn_tok,
   output logic [IDX_W-1:0]           dn_slot,
   input  wire logic [CNT_W-1:0]      count,
   input  wire ipv4lpm_pkg::wr_type   wr,
   input  wire logic [IDX_W-1:0]      wr_slot
);

   ipv4lpm_pkg::entry_type entry_ff;
   ipv4lpm_pkg::tok_type   tok_ff;
   ipv4lpm_pkg::tok_type   tok_in;
   logic [IDX_W-1:0]       slot_ff;
   logic [IDX_W-1:0]       slot_in;
   logic                   live;
   logic [31:0]            mask;

   always_comb begin
      tok_in  = up_tok;
      slot_in = up_slot;
      live    = CNT_W'(IDX) < count;
      mask    = ipv4lpm_pkg::len_mask(entry_ff.len);
      if (live && !up_tok.found && entry_ff.prefix == up_tok.key.prefix
          && entry_ff.len == up_tok.key.len) begin
         tok_in.found = 1'b1;
         slot_in      = IDX_W'(IDX);
      end
      if (live && ((up_tok.addr & mask) == (entry_ff.prefix & mask))
          && (!up_tok.hit || entry_ff.len > up_tok.best.len
              || (entry_ff.len == up_tok.best.len
                  && entry_ff.metric < up_tok.best.metric))) begin
         tok_in.hit  = 1'b1;
         tok_in.best = entry_ff;
      end
      if (CNT_W'(IDX + 1) == count) begin
         tok_in.last = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= '0;
         slot_ff  <= '0;
         entry_ff <= '0;
      end else begin
         tok_ff  <= tok_in;
         slot_ff <= slot_in;
         if (wr.we && wr_slot == IDX_W'(IDX)) begin
            entry_ff <= wr.ent;
         end
      end
   end

   assign dn_tok  = tok_ff;
   assign dn_slot = slot_ff;

endmodule
`default_nettype wire

// ===== sv/ipv4_longest_prefix_route_table_unit.sv =====
// top level of the ipv4 longest prefix route table
// Channels: req_ carries one operation item (upsert, remove or lookup),
// rsp_ carries exactly one result item per request, both valid/stall.
// The table is a row of TABLE_DEPTH cells, one route per cell. An accepted
// item travels down the row as a token, one cell per cycle, collecting the
// exact-match slot, the best lookup route and the last valid route.
// When the token leaves the last cell the table write (replace, append or
// swap-in of the last route) and the count update happen in that cycle.
// An accepted item passes through the cell registers, the hold register
// and the output register to rsp_valid. One item is in flight at a time:
// the next is accepted once the previous result is in the output register.
// A new item is accepted while the previous result waits on a stalled
// rsp_ channel; its result is then held until the output register frees.
// Reset is synchronous and clears every route and the route count; the
// block takes items in the cycle after reset is released.
`timescale 1ns / 1ps
`default_nettype none
`include "ipv4_longest_prefix_route_table_unit_defines.svh"
module ipv4_longest_prefix_route_table_unit #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire ipv4lpm_pkg::req_type req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output ipv4lpm_pkg::rsp_type      rsp_payload
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   ipv4lpm_pkg::tok_type   tok_chain  [TABLE_DEPTH+1];
   logic [IDX_W-1:0]       slot_chain [TABLE_DEPTH+1];
   ipv4lpm_pkg::tok_type   end_tok;
   ipv4lpm_pkg::wr_type    wr;
   logic [IDX_W-1:0]       wr_slot;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [CNT_W+6:0]       count_ext;
   ipv4lpm_pkg::rsp_type   res;
   ipv4lpm_pkg::rsp_type   hold_ff;
   ipv4lpm_pkg::rsp_type   rsp_ff;
   logic                   rsp_valid_ff;
   ipv4lpm_pkg::state_type state_ff;
   ipv4lpm_pkg::state_type state_in;
   logic                   accept;
   logic                   load;

   assign req_stall = state_ff != ipv4lpm_pkg::FSM_IDLE;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      tok_chain[0]                = '0;
      tok_chain[0].valid          = accept;
      tok_chain[0].op             = req_payload.op;
      tok_chain[0].key.prefix     = req_payload.prefix;
      tok_chain[0].key.len        = req_payload.prefix_len;
      tok_chain[0].key.metric     = req_payload.metric;
      tok_chain[0].key.hop        = req_payload.next_hop;
      tok_chain[0].addr           = req_payload.lookup_addr;
      slot_chain[0]               = '0;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      ipv4lpm_cell #(
         .IDX   (i),
         .IDX_W (IDX_W),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .up_tok  (tok_chain[i]),
         .up_slot (slot_chain[i]),
         .dn_tok  (tok_chain[i+1]),
         .dn_slot (slot_chain[i+1]),
         .count   (count_ff),
         .wr      (wr),
         .wr_slot (wr_slot)
      );
   end

   assign end_tok = tok_chain[TABLE_DEPTH];

   always_comb begin
      wr         = '0;
      wr_slot    = slot_chain[TABLE_DEPTH];
      count_in   = count_ff;
      res        = '0;
      res.status = ipv4lpm_pkg::ST_MISS;
      if (end_tok.valid) begin
         case (end_tok.op)
            ipv4lpm_pkg::OP_UPSERT: begin
               if (end_tok.key.len > ipv4lpm_pkg::MAX_LEN) begin
                  res.status = ipv4lpm_pkg::ST_BAD_LEN;
               end else if (end_tok.found) begin
                  wr.we      = 1'b1;
                  wr.ent     = end_tok.key;
                  res.status = ipv4lpm_pkg::ST_OK;
               end else if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                  res.status = ipv4lpm_pkg::ST_FULL;
               end else begin
                  wr.we      = 1'b1;
                  wr.ent     = end_tok.key;
                  wr_slot    = count_ff[IDX_W-1:0];
                  count_in   = count_ff + CNT_W'(1);
                  res.status = ipv4lpm_pkg::ST_OK;
               end
            end
            ipv4lpm_pkg::OP_REMOVE: begin
               if (end_tok.found) begin
                  wr.we      = 1'b1;
                  wr.ent     = end_tok.last;
                  count_in   = count_ff - CNT_W'(1);
                  res.status = ipv4lpm_pkg::ST_OK;
               end
            end
            ipv4lpm_pkg::OP_LOOKUP: begin
               if (end_tok.hit) begin
                  res.status      = ipv4lpm_pkg::ST_OK;
                  res.best_prefix = end_tok.best.prefix;
                  res.best_len    = end_tok.best.len;
                  res.best_metric = end_tok.best.metric;
                  res.best_hop    = end_tok.best.hop;
               end
            end
            default: begin
               res.status = ipv4lpm_pkg::ST_MISS;
            end
         endcase
      end
      count_ext       = {7'd0, count_in};
      res.entry_count = count_ext[6:0];
   end

   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      case (state_ff)
         ipv4lpm_pkg::FSM_IDLE: begin
            if (accept) begin
               state_in = ipv4lpm_pkg::FSM_SCAN;
            end
         end
         ipv4lpm_pkg::FSM_SCAN: begin
            if (end_tok.valid) begin
               state_in = ipv4lpm_pkg::FSM_HOLD;
            end
         end
         ipv4lpm_pkg::FSM_HOLD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load     = 1'b1;
               state_in = ipv4lpm_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = ipv4lpm_pkg::FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ipv4lpm_pkg::FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (end_tok.valid) begin
         hold_ff <= res;
      end
      if (load) begin
         rsp_ff <= hold_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `ASSERT_IMPLIES(a_end_in_scan, clock, reset, end_tok.valid, state_ff == ipv4lpm_pkg::FSM_SCAN)
   `ASSERT_NEXT(a_accept_scan, clock, reset, accept, state_ff == ipv4lpm_pkg::FSM_SCAN)

endmodule
`default_nettype wire

// ===== sim/tb_ipv4_longest_prefix_route_table_unit.sv =====
// testbench for the ipv4 longest prefix route table unit
`timescale 1ns / 1ps
module tb_ipv4_longest_prefix_route_table_unit;

   localparam int DEPTH = 64;
   localparam int CYCLE_LIMIT = 400000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   ipv4lpm_pkg::req_type req_payload;
   logic                 rsp_valid;
   logic                 rsp_stall;
   ipv4lpm_pkg::rsp_type rsp_payload;

   ipv4lpm_pkg::req_type pending_q[$];
   ipv4lpm_pkg::rsp_type expected_q[$];

   logic [31:0] tbl_prefix[DEPTH];
   logic [5:0]  tbl_len[DEPTH];
   logic [31:0] tbl_metric[DEPTH];
   logic [31:0] tbl_hop[DEPTH];
   int          route_count;

   int   error_count;
   int   sent_count;
   int   got_count;
   int   hit_count;
   int   cycle_count;
   bit   stim_done;
   bit   calm;
   logic req_taken;

   ipv4_longest_prefix_route_table_unit #(.TABLE_DEPTH(DEPTH)) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [31:0] prefix_mask(input logic [5:0] len);
      logic [31:0] m;
      m = 32'd0;
      for (int b = 0; b < 32; b++) begin
         if (b < len) m[31 - b] = 1'b1;
      end
      return m;
   endfunction

   function automatic int find_route(input logic [31:0] pfx, input logic [5:0] len);
      for (int i = 0; i < route_count; i++) begin
         if (tbl_prefix[i] == pfx && tbl_len[i] == len) return i;
      end
      return -1;
   endfunction

   function automatic ipv4lpm_pkg::rsp_type apply_route_op(input ipv4lpm_pkg::req_type r);
      ipv4lpm_pkg::rsp_type res;
      int          slot;
      int          last;
      bit          hit;
      logic [31:0] m;
      res = '0;
      res.status = ipv4lpm_pkg::ST_MISS;
      slot = find_route(r.prefix, r.prefix_len);
      if (r.op == ipv4lpm_pkg::OP_UPSERT) begin
         if (r.prefix_len > ipv4lpm_pkg::MAX_LEN) begin
            res.status = ipv4lpm_pkg::ST_BAD_LEN;
         end else if (slot < 0 && route_count >= DEPTH) begin
            res.status = ipv4lpm_pkg::ST_FULL;
         end else begin
            if (slot < 0) begin
               slot = route_count;
               route_count++;
            end
            tbl_prefix[slot] = r.prefix;
            tbl_len[slot] = r.prefix_len;
            tbl_metric[slot] = r.metric;
            tbl_hop[slot] = r.next_hop;
            res.status = ipv4lpm_pkg::ST_OK;
         end
      end else if (r.op == ipv4lpm_pkg::OP_REMOVE) begin
         if (slot >= 0) begin
            last = route_count - 1;
            tbl_prefix[slot] = tbl_prefix[last];
            tbl_len[slot] = tbl_len[last];
            tbl_metric[slot] = tbl_metric[last];
            tbl_hop[slot] = tbl_hop[last];
            route_count = last;
            res.status = ipv4lpm_pkg::ST_OK;
         end
      end else if (r.op == ipv4lpm_pkg::OP_LOOKUP) begin
         hit = 1'b0;
         for (int i = 0; i < route_count; i++) begin
            m = prefix_mask(tbl_len[i]);
            if ((r.lookup_addr & m) == (tbl_prefix[i] & m)) begin
               if (!hit || tbl_len[i] > res.best_len ||
                   (tbl_len[i] == res.best_len && tbl_metric[i] < res.best_metric)) begin
                  hit = 1'b1;
                  res.best_prefix = tbl_prefix[i];
                  res.best_len = tbl_len[i];
                  res.best_metric = tbl_metric[i];
                  res.best_hop = tbl_hop[i];
               end
            end
         end
         if (hit) res.status = ipv4lpm_pkg::ST_OK;
      end
      res.entry_count = route_count[6:0];
      return res;
   endfunction

   function automatic ipv4lpm_pkg::req_type make_item(input ipv4lpm_pkg::op_type op,
                                                      input logic [31:0] pfx,
                                                      input logic [5:0] len,
                                                      input logic [31:0] met,
                                                      input logic [31:0] hop,
                                                      input logic [31:0] addr);
      ipv4lpm_pkg::req_type r;
      r.op = op;
      r.prefix = pfx;
      r.prefix_len = len;
      r.metric = met;
      r.next_hop = hop;
      r.lookup_addr = addr;
      return r;
   endfunction

   // prefixes drawn from a small pool so exact matches and overlaps are common
   function automatic logic [31:0] pool_prefix();
      logic [31:0] base;
      base = {8'd10, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), 8'd0};
      if ($urandom_range(0, 4) == 0) base = $urandom();
      return base;
   endfunction

   function automatic logic [5:0] pool_len();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 6'($urandom_range(0, 63));
      if (k < 3) return 6'd8;
      if (k < 5) return 6'd16;
      if (k < 7) return 6'd24;
      return 6'($urandom_range(0, 32));
   endfunction

   initial begin
      ipv4lpm_pkg::req_type r;
      int                   pick;
      int                   u;
      ipv4lpm_pkg::op_type  op;
      logic [31:0]          bits;
      reset = 1'b1;
      error_count = 0;
      sent_count = 0;
      got_count = 0;
      hit_count = 0;
      stim_done = 1'b0;
      route_count = 0;
      for (int i = 0; i < DEPTH; i++) begin
         tbl_prefix[i] = '0;
         tbl_len[i] = '0;
         tbl_metric[i] = '0;
         tbl_hop[i] = '0;
      end

      // directed part
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_LOOKUP, '0, '0, '0, '0, 32'h0102_0304));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_REMOVE, 32'h0A00_0000, 6'd8, '0, '0, '0));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_UPSERT, 32'h0A00_0000, 6'd33, 32'd1,
                                    32'd1, '0));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_UPSERT, 32'hFFFF_FFFF, 6'd63, 32'd1,
                                    32'd1, '0));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_UPSERT, 32'hDEAD_BEEF, 6'd0,
                                    32'hFFFF_FFFF, 32'h0000_0001, '0));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFF));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_UPSERT, 32'h0A01_02FF, 6'd24, 32'd5,
                                    32'hC0A8_0001, '0));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_UPSERT, 32'h0A01_0000, 6'd16, 32'd0,
                                    32'hC0A8_0002, '0));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_UPSERT, 32'h0A01_02FE, 6'd24, 32'd5,
                                    32'hC0A8_0003, '0));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_UPSERT, 32'hFFFF_FFFF, 6'd32, 32'd0,
                                    32'hFFFF_FFFF, '0));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_LOOKUP, '0, '0, '0, '0, 32'h0A01_0203));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_LOOKUP, '0, '0, '0, '0, 32'h0A01_0903));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_LOOKUP, '0, '0, '0, '0, 32'hFFFF_FFFF));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_UPSERT, 32'h0A01_02FF, 6'd24, 32'd9,
                                    32'hC0A8_0009, '0));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_LOOKUP, '0, '0, '0, '0, 32'h0A01_0201));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_REMOVE, 32'hDEAD_BEEF, 6'd0, '0, '0, '0));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_REMOVE, 32'h0A01_0000, 6'd40, '0, '0, '0));
      pending_q.push_back(make_item(ipv4lpm_pkg::op_type'(2'd3), 32'hFFFF_FFFF, 6'd63,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_LOOKUP, '0, '0, '0, '0, 32'h7777_0000));
      // fill to full, then appends that find the table full, then a replace while full
      for (int i = 0; i < DEPTH + 1; i++) begin
         pending_q.push_back(make_item(ipv4lpm_pkg::OP_UPSERT, 32'h2000_0000 + i, 6'd32,
                                       32'(i), 32'(i), '0));
      end
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_UPSERT, 32'h2000_0000, 6'd32, 32'd7,
                                    32'd7, '0));
      pending_q.push_back(make_item(ipv4lpm_pkg::OP_LOOKUP, '0, '0, '0, '0, 32'h2000_0000));
      for (int i = 0; i < DEPTH; i++) begin
         pending_q.push_back(make_item(ipv4lpm_pkg::OP_REMOVE, 32'h2000_0000 + i, 6'd32,
                                       '0, '0, '0));
      end

      // random part
      for (int n = 0; n < 250; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) op = ipv4lpm_pkg::OP_UPSERT;
         else if (pick < 60) op = ipv4lpm_pkg::OP_REMOVE;
         else if (pick < 97) op = ipv4lpm_pkg::OP_LOOKUP;
         else op = ipv4lpm_pkg::op_type'(2'd3);
         r = make_item(op, pool_prefix(), pool_len(), $urandom(), $urandom(), '0);
         if ($urandom_range(0, 3) == 0) r.metric = 32'($urandom_range(0, 3));
         bits = pool_prefix();
         u = $urandom_range(0, 2);
         if (u == 0) r.lookup_addr = $urandom();
         else r.lookup_addr = {bits[31:8], 8'($urandom())};
         pending_q.push_back(r);
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
      end else if (!req_valid || req_taken) begin
         if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 21)) begin
            req_valid <= 1'b1;
            req_payload <= pending_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   initial begin
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b1;
   end

   // quiet stretch in the middle of the run
   always @(negedge clock) begin
      calm <= (cycle_count > 6000 && cycle_count < 12000);
      rsp_stall <= reset ? 1'b1 : (!calm && $urandom_range(0, 99) < 21);
   end

   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall && !reset;
   end

   // monitor
   always @(posedge clock) begin
      ipv4lpm_pkg::rsp_type exp_rsp;
      cycle_count <= reset ? 0 : cycle_count + 1;
      if (!reset && req_valid && !req_stall) begin
         expected_q.push_back(apply_route_op(req_payload));
         sent_count++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got_count++;
         if (expected_q.size() == 0) begin
            $display("%0t: result with none expected, actual %h", $time, rsp_payload);
            error_count++;
         end else begin
            exp_rsp = expected_q.pop_front();
            if (exp_rsp.status == ipv4lpm_pkg::ST_OK && exp_rsp.best_len != 0) hit_count++;
            if (rsp_payload.status !== exp_rsp.status ||
                rsp_payload.best_prefix !== exp_rsp.best_prefix ||
                rsp_payload.best_len !== exp_rsp.best_len ||
                rsp_payload.best_metric !== exp_rsp.best_metric ||
                rsp_payload.best_hop !== exp_rsp.best_hop ||
                rsp_payload.entry_count !== exp_rsp.entry_count) begin
               $display("%0t: mismatch expected %h actual %h", $time, exp_rsp, rsp_payload);
               error_count++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      req_taken = 1'b0;
      calm = 1'b0;
      wait (!reset);
      while ((pending_q.size() > 0 || req_valid || expected_q.size() > 0)
             && cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** ipv4_longest_prefix_route_table_unit: FAILED **");
         $finish;
      end else begin
         repeat (DEPTH + 10) @(posedge clock);
         $display("covered %0d items, %0d results, %0d nonzero-length hits",
                  sent_count, got_count, hit_count);
         if (error_count == 0 && expected_q.size() == 0) begin
            $display("** ipv4_longest_prefix_route_table_unit: PASSED **");
         end else begin
            $display("** ipv4_longest_prefix_route_table_unit: FAILED **");
         end
         $finish;
      end
   end

endmodule
